### hw/rtl/lcd_mode_timing_stat_controller_core_defines.svh
// ----------------------------------------------------------------------------
// LCD mode timing controller assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_STAT_CONTROLLER_CORE_DEFINES_SVH
`define LCD_MODE_TIMING_STAT_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LMT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lmt_pkg.sv
// ----------------------------------------------------------------------------
// LCD mode timing package
// Opcodes, register addresses, mode codes, timing constants and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register page addresses (low byte)
    localparam logic [7:0] ADDR_LCDC = 8'h40;
    localparam logic [7:0] ADDR_STAT = 8'h41;
    localparam logic [7:0] ADDR_SCY  = 8'h42;
    localparam logic [7:0] ADDR_SCX  = 8'h43;
    localparam logic [7:0] ADDR_LY   = 8'h44;
    localparam logic [7:0] ADDR_LYC  = 8'h45;
    localparam logic [7:0] ADDR_BGP  = 8'h47;
    localparam logic [7:0] ADDR_OBP0 = 8'h48;
    localparam logic [7:0] ADDR_OBP1 = 8'h49;
    localparam logic [7:0] ADDR_WY   = 8'h4A;
    localparam logic [7:0] ADDR_WX   = 8'h4B;

    // Timing
    localparam logic [8:0] OAM_END_DOT       = 9'd80;
    localparam logic [8:0] DRAW_END_DOT      = 9'd252;
    localparam logic [8:0] LINE_DOTS         = 9'd456;
    localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
    localparam logic [7:0] FRAME_LINES       = 8'd154;

    localparam logic [7:0] STAT_WRITE_MASK = 8'hF8;
    localparam logic [7:0] UNMAPPED_READ   = 8'hFF;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } lmt_mode_t;

    typedef struct packed {
        logic [8:0] dot;
        logic [7:0] line;
        lmt_mode_t  mode;
        logic [7:0] lcdc;
        logic [7:0] stat;
        logic [7:0] scy;
        logic [7:0] scx;
        logic [7:0] lyc;
        logic [7:0] wy;
        logic [7:0] wx;
        logic [7:0] bgp;
        logic [7:0] obp0;
        logic [7:0] obp1;
    } lmt_state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_irq;
        logic       stat_irq;
        lmt_mode_t  lcd_mode;
        logic [7:0] line_number;
    } lmt_result_t;

    localparam lmt_state_t LMT_STATE_RESET = '{
        dot:  9'd0,
        line: 8'd0,
        mode: MODE_OAM,
        lcdc: 8'h00,
        stat: 8'h00,
        scy:  8'h00,
        scx:  8'h00,
        lyc:  8'h00,
        wy:   8'h00,
        wx:   8'h00,
        bgp:  8'hFC,
        obp0: 8'hFF,
        obp1: 8'hFF
    };

endpackage

`default_nettype wire

### hw/rtl/lmt_step.sv
// ----------------------------------------------------------------------------
// LCD mode timing step logic
// Next state and result word for one item, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_step (
    input  wire logic [1:0]         opcode,
    input  wire logic [7:0]         reg_addr,
    input  wire logic [7:0]         write_data,
    input  wire lmt_pkg::lmt_state_t  state,
    output lmt_pkg::lmt_state_t       state_next,
    output lmt_pkg::lmt_result_t      result
);
    import lmt_pkg::*;

    lmt_state_t ns;
    logic [7:0] rd;
    logic       vb;
    logic       si;
    logic       do_cmp;
    logic       do_enter;
    lmt_mode_t  enter_m;
    logic [8:0] dot_inc;
    logic [7:0] line_inc;

    always_comb
    begin
        ns       = state;
        rd       = UNMAPPED_READ;
        vb       = 1'b0;
        si       = 1'b0;
        do_cmp   = 1'b0;
        do_enter = 1'b0;
        enter_m  = MODE_HBLANK;
        dot_inc  = state.dot + 9'd1;
        line_inc = state.line + 8'd1;

        case (opcode)
            OP_TICK:
            begin
                if (!state.lcdc[7])
                begin
                    ns.dot       = '0;
                    ns.line      = '0;
                    ns.mode      = MODE_HBLANK;
                    ns.stat[1:0] = 2'b00;
                end
                else
                begin
                    ns.dot = dot_inc;
                    case (state.mode)
                        MODE_OAM:
                        begin
                            if (dot_inc >= OAM_END_DOT)
                            begin
                                do_enter = 1'b1;
                                enter_m  = MODE_DRAW;
                            end
                        end
                        MODE_DRAW:
                        begin
                            if (dot_inc >= DRAW_END_DOT)
                            begin
                                do_enter = 1'b1;
                                enter_m  = MODE_HBLANK;
                            end
                        end
                        MODE_HBLANK:
                        begin
                            if (dot_inc >= LINE_DOTS)
                            begin
                                ns.dot   = '0;
                                ns.line  = line_inc;
                                do_cmp   = 1'b1;
                                do_enter = 1'b1;
                                enter_m  = (line_inc == VBLANK_FIRST_LINE) ?
                                           MODE_VBLANK : MODE_OAM;
                            end
                        end
                        default:
                        begin
                            // vblank: count lines, wrap to the top of frame
                            if (dot_inc >= LINE_DOTS)
                            begin
                                ns.dot = '0;
                                do_cmp = 1'b1;
                                if (line_inc >= FRAME_LINES)
                                begin
                                    ns.line  = '0;
                                    do_enter = 1'b1;
                                    enter_m  = MODE_OAM;
                                end
                                else
                                begin
                                    ns.line = line_inc;
                                end
                            end
                        end
                    endcase
                end
            end
            OP_READ:
            begin
                case (reg_addr)
                    ADDR_LCDC: rd = state.lcdc;
                    ADDR_STAT: rd = {state.stat[7:2], state.mode};
                    ADDR_SCY:  rd = state.scy;
                    ADDR_SCX:  rd = state.scx;
                    ADDR_LY:   rd = state.line;
                    ADDR_LYC:  rd = state.lyc;
                    ADDR_BGP:  rd = state.bgp;
                    ADDR_OBP0: rd = state.obp0;
                    ADDR_OBP1: rd = state.obp1;
                    ADDR_WY:   rd = state.wy;
                    ADDR_WX:   rd = state.wx;
                    default:   rd = UNMAPPED_READ;
                endcase
            end
            OP_WRITE:
            begin
                case (reg_addr)
                    ADDR_LCDC:
                    begin
                        ns.lcdc = write_data;
                        if (state.lcdc[7] && !write_data[7])
                        begin
                            ns.dot       = '0;
                            ns.line      = '0;
                            ns.mode      = MODE_HBLANK;
                            ns.stat[1:0] = 2'b00;
                        end
                    end
                    ADDR_STAT:
                        ns.stat = (write_data & STAT_WRITE_MASK) |
                                  (state.stat & ~STAT_WRITE_MASK);
                    ADDR_SCY:  ns.scy = write_data;
                    ADDR_SCX:  ns.scx = write_data;
                    ADDR_LY:
                    begin
                        ns.line = '0;
                        ns.dot  = '0;
                        do_cmp  = 1'b1;
                    end
                    ADDR_LYC:
                    begin
                        ns.lyc = write_data;
                        do_cmp = 1'b1;
                    end
                    ADDR_BGP:  ns.bgp  = write_data;
                    ADDR_OBP0: ns.obp0 = write_data;
                    ADDR_OBP1: ns.obp1 = write_data;
                    ADDR_WY:   ns.wy   = write_data;
                    ADDR_WX:   ns.wx   = write_data;
                    default:   ;
                endcase
            end
            default: ;
        endcase

        // LY/LYC coincidence
        if (do_cmp)
        begin
            if (ns.line == ns.lyc)
            begin
                ns.stat[2] = 1'b1;
                if (ns.stat[6])
                    si = 1'b1;
            end
            else
            begin
                ns.stat[2] = 1'b0;
            end
        end

        // mode entry requests
        if (do_enter)
        begin
            ns.mode      = enter_m;
            ns.stat[1:0] = enter_m;
            case (enter_m)
                MODE_HBLANK: if (ns.stat[3]) si = 1'b1;
                MODE_VBLANK:
                begin
                    vb = 1'b1;
                    if (ns.stat[4])
                        si = 1'b1;
                end
                MODE_OAM:    if (ns.stat[5]) si = 1'b1;
                default:     ;
            endcase
        end
    end

    assign state_next         = ns;
    assign result.read_data   = rd;
    assign result.vblank_irq  = vb;
    assign result.stat_irq    = si;
    assign result.lcd_mode    = ns.mode;
    assign result.line_number = ns.line;

endmodule

`default_nettype wire

### hw/rtl/lcd_mode_timing_stat_controller_core.sv
// An accepted word passes from the input register into the result register.
// Throughput: one word per cycle unless the output stalls; the input register
//   frees up in the same cycle its word moves into the result register.
// Reset (rst_n low, async): timing at line 0 dot 0 in OAM scan mode, LCD off,
//   palettes at power-on values, both pipeline registers empty.
// ----------------------------------------------------------------------------
// LCD mode timing and STAT interrupt controller, top level
// Input register -> step logic + LCD register file -> result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_mode_timing_stat_controller_core_defines.svh"

module lcd_mode_timing_stat_controller_core (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          opcode,
    input  wire logic [7:0]          reg_addr,
    input  wire logic [7:0]          write_data,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               read_data,
    output logic                     vblank_irq,
    output logic                     stat_irq,
    output lmt_pkg::lmt_mode_t       lcd_mode,
    output logic [7:0]               line_number
);
    import lmt_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  opcode_reg;
    logic [7:0]  reg_addr_reg;
    logic [7:0]  write_data_reg;

    // architectural state (LCD registers and dot/line counters)
    lmt_state_t  state_reg;
    lmt_state_t  state_next;

    // result stage
    logic        out_valid_reg;
    lmt_result_t result_reg;
    lmt_result_t result_next;

    // A word leaves the input register when the result register is empty
    // or its word is taken this cycle.
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg     <= opcode;
            reg_addr_reg   <= reg_addr;
            write_data_reg <= write_data;
        end
    end

    lmt_step u_step (
        .opcode     (opcode_reg),
        .reg_addr   (reg_addr_reg),
        .write_data (write_data_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // State commits exactly once per word, when it moves to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LMT_STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = result_reg.read_data;
    assign vblank_irq  = result_reg.vblank_irq;
    assign stat_irq    = result_reg.stat_irq;
    assign lcd_mode    = result_reg.lcd_mode;
    assign line_number = result_reg.line_number;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LMT_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg,
        "word moved to result stage but out_valid not set")
    `LMT_ASSERT_IMPL(a_lcd_off_timing_idle, !state_reg.lcdc[7],
        (state_reg.dot == 9'd0) && (state_reg.line == 8'd0),
        "LCD off but dot or line counter nonzero")
    `LMT_ASSERT_IMPL(a_vblank_irq_mode, out_valid_reg && result_reg.vblank_irq,
        result_reg.lcd_mode == MODE_VBLANK,
        "vblank request without vblank mode")

endmodule

`default_nettype wire
